FILE: hw/rtl/crc_rx_pkg.sv
// Package for the CRC-32 framed byte receiver.
// Holds shared constants, the result and beat types, and the CRC byte update.
// No dependencies.
`timescale 1ns / 1ps

package crc_rx_pkg;

    // Frame layout
    localparam int HEADER_BYTES      = 7;
    localparam int LENGTH_WIDTH_DEF  = 16;
    localparam int IDX_W             = 16;   // payload_index / frame_length width

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_SOF_FIRST     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOF_SECOND    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

    // Configuration reset values
    localparam logic [7:0]  SOF_FIRST_RST     = 8'hAA;
    localparam logic [7:0]  SOF_SECOND_RST    = 8'h55;
    localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd4096;

    // Result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_BAD_CRC  = 2'd2;
    localparam logic [1:0] KIND_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [1:0]       result_kind;
        logic [7:0]       payload_byte;
        logic [IDX_W-1:0] payload_index;
        logic [7:0]       frame_context;
        logic [7:0]       frame_type;
        logic [7:0]       frame_sequence;
        logic [IDX_W-1:0] frame_length;
    } result_t;

    // Registered input beat handed to the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } rx_beat_t;

    // Fold one byte into a reflected CRC-32
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/crc_rx_byte_if.sv
// Input channel interface: one received byte per beat.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface crc_rx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/crc_rx_result_if.sv
// Result channel interface: payload bytes and frame-end reports.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface crc_rx_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_context;
    logic [7:0]  frame_type;
    logic [7:0]  frame_sequence;
    logic [15:0] frame_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_index, output frame_context, output frame_type,
                    output frame_sequence, output frame_length, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_index, input frame_context, input frame_type,
                    input frame_sequence, input frame_length, output ready);
endinterface

FILE: hw/rtl/crc32_frame_receiver_unit.sv
// Top level of the CRC-32 framed byte receiver.
// Depends on crc_rx_pkg, crc_rx_byte_if, crc_rx_result_if and the crc_rx_* stages.
`timescale 1ns / 1ps

// The receiver takes one byte per cycle on rx and, with result ready held high,
// sustains that rate indefinitely. Each byte passes an input register, one pass
// of parse and CRC-32 byte update logic, and an output register, from which its
// result is presented on result. Payload bytes come out as they arrive; each frame
// ends with one good, bad-CRC or over-limit report carrying the header fields. A
// stall on result backs up into rx.ready only for bytes that produce a result while
// a previous result still waits. The user writes configuration registers through
// cfg_we/cfg_index/cfg_data while the block idles; the block does not enforce it.

module crc32_frame_receiver_unit #(
    parameter int LENGTH_WIDTH = crc_rx_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [crc_rx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [crc_rx_pkg::CFG_DATA_W-1:0]  cfg_data,
    crc_rx_byte_if.sink                        rx,
    crc_rx_result_if.source                    result
);
    import crc_rx_pkg::*;

    rx_beat_t beat;
    result_t  res;
    logic     advance;
    logic     has_result;
    logic     out_free;

    crc_rx_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (advance),
        .beat    (beat)
    );

    crc_rx_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .beat       (beat),
        .out_free   (out_free),
        .advance    (advance),
        .has_result (has_result),
        .res        (res)
    );

    crc_rx_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && has_result),
        .res      (res),
        .out_free (out_free),
        .result   (result)
    );

endmodule

FILE: hw/rtl/crc_rx_in_stage.sv
// Input register of the receiver: captures one byte beat per cycle while the held beat moves on.
// Depends on crc_rx_pkg and crc_rx_byte_if.
`timescale 1ns / 1ps

module crc_rx_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    crc_rx_byte_if.sink          rx,
    input  logic                 advance,
    output crc_rx_pkg::rx_beat_t beat
);
    import crc_rx_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    // Accept whenever empty or the held beat moves on this cycle
    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign beat.valid   = valid_reg;
    assign beat.rx_byte = byte_reg;

endmodule

FILE: hw/rtl/crc_rx_parser.sv
// Frame parser: start-byte hunt, header capture, payload pass-through and CRC-32
// check, one byte per cycle unless the result slot stalls it. Depends on crc_rx_pkg.
`timescale 1ns / 1ps

module crc_rx_parser #(
    parameter int LENGTH_WIDTH = crc_rx_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [crc_rx_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [crc_rx_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  crc_rx_pkg::rx_beat_t                   beat,
    input  logic                                   out_free,
    output logic                                   advance,
    output logic                                   has_result,
    output crc_rx_pkg::result_t                    res
);
    import crc_rx_pkg::*;

    localparam logic [2:0] PH_SOF1 = 3'd0;
    localparam logic [2:0] PH_SOF2 = 3'd1;
    localparam logic [2:0] PH_HDR  = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;

    localparam int HDR_STORE = HEADER_BYTES - 1;   // last header byte is used on arrival
    localparam int HDR_IDX_W = $clog2(HDR_STORE);
    localparam logic [32:0] LEN_CAP = (33'd1 << LENGTH_WIDTH) - 33'd1;

    // Configuration
    logic [7:0]  sof1_reg;
    logic [7:0]  sof2_reg;
    logic [15:0] limit_reg;

    // Parse state
    logic [2:0]       phase_reg,   phase_next;
    logic [15:0]      cnt_reg,     cnt_next;
    logic [31:0]      crc_reg,     crc_next;
    logic [23:0]      rcrc_reg,    rcrc_next;
    logic [1:0]       crc_cnt_reg, crc_cnt_next;
    logic [7:0]       hdr_reg [HDR_STORE];
    logic [IDX_W-1:0] flen_reg,    flen_next;
    logic [15:0]      plen_reg,    plen_next;

    logic [7:0]  b;
    logic [31:0] crc_upd;
    logic [31:0] len32;
    logic [31:0] len_sat;
    logic        too_long;
    logic        hdr_wr;
    logic [16:0] cnt_inc;

    assign b       = beat.rx_byte;
    assign crc_upd = crc_feed(crc_reg, b);
    assign len32   = {b, hdr_reg[5], hdr_reg[4], hdr_reg[3]};
    assign len_sat = (len32 > LEN_CAP[31:0]) ? LEN_CAP[31:0] : len32;
    assign too_long = len32 > {16'd0, limit_reg};
    assign cnt_inc = {1'b0, cnt_reg} + 17'd1;

    // Step the frame state machine for the byte at the input register
    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        crc_next     = crc_reg;
        rcrc_next    = rcrc_reg;
        crc_cnt_next = crc_cnt_reg;
        flen_next    = flen_reg;
        plen_next    = plen_reg;
        hdr_wr       = 1'b0;
        has_result   = 1'b0;
        res.result_kind    = KIND_PAYLOAD;
        res.payload_byte   = 8'd0;
        res.payload_index  = '0;
        res.frame_context  = hdr_reg[0];
        res.frame_type     = hdr_reg[1];
        res.frame_sequence = hdr_reg[2];
        res.frame_length   = flen_reg;

        case (phase_reg)
            PH_SOF2:
            begin
                if (b == sof2_reg)
                begin
                    phase_next = PH_HDR;
                    cnt_next   = 16'd0;
                    crc_next   = CRC_INIT;
                end
                else if (b != sof1_reg)
                begin
                    phase_next = PH_SOF1;
                end
            end
            PH_HDR:
            begin
                crc_next = crc_upd;
                if (cnt_reg < 16'(HDR_STORE))
                begin
                    hdr_wr   = 1'b1;
                    cnt_next = cnt_inc[15:0];
                end
                else
                begin
                    cnt_next     = 16'd0;
                    crc_cnt_next = 2'd0;
                    rcrc_next    = 24'd0;
                    flen_next    = len_sat[IDX_W-1:0];
                    plen_next    = len32[15:0];
                    if (too_long)
                    begin
                        phase_next       = PH_SOF1;
                        has_result       = 1'b1;
                        res.result_kind  = KIND_TOO_LONG;
                        res.frame_length = len_sat[IDX_W-1:0];
                    end
                    else if (len32 != 32'd0)
                    begin
                        phase_next = PH_PAY;
                    end
                    else
                    begin
                        phase_next = PH_CRC;
                    end
                end
            end
            PH_PAY:
            begin
                crc_next          = crc_upd;
                has_result        = 1'b1;
                res.result_kind   = KIND_PAYLOAD;
                res.payload_byte  = b;
                res.payload_index = cnt_reg;
                cnt_next          = cnt_inc[15:0];
                if (cnt_inc >= {1'b0, plen_reg})
                begin
                    phase_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (crc_cnt_reg != 2'd3)
                begin
                    rcrc_next[8*crc_cnt_reg +: 8] = b;
                    crc_cnt_next = crc_cnt_reg + 2'd1;
                end
                else
                begin
                    has_result      = 1'b1;
                    res.result_kind = (~crc_reg == {b, rcrc_reg}) ? KIND_GOOD : KIND_BAD_CRC;
                    crc_cnt_next    = 2'd0;
                    rcrc_next       = 24'd0;
                    phase_next      = PH_SOF1;
                end
            end
            default:
            begin
                phase_next = (b == sof1_reg) ? PH_SOF2 : PH_SOF1;
            end
        endcase
    end

    // Move on once the result slot can take what this byte produces
    assign advance = beat.valid && (!has_result || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SOF1;
            cnt_reg     <= 16'd0;
            crc_reg     <= CRC_INIT;
            rcrc_reg    <= 24'd0;
            crc_cnt_reg <= 2'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            crc_reg     <= crc_next;
            rcrc_reg    <= rcrc_next;
            crc_cnt_reg <= crc_cnt_next;
        end
    end

    // Header store and frame lengths
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            flen_reg <= flen_next;
            plen_reg <= plen_next;
            if (hdr_wr)
            begin
                hdr_reg[cnt_reg[HDR_IDX_W-1:0]] <= b;
            end
        end
    end

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof1_reg  <= SOF_FIRST_RST;
            sof2_reg  <= SOF_SECOND_RST;
            limit_reg <= PAYLOAD_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOF_FIRST:     sof1_reg  <= cfg_data[7:0];
                REG_SOF_SECOND:    sof2_reg  <= cfg_data[7:0];
                REG_PAYLOAD_LIMIT: limit_reg <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // A payload count never reaches the frame length while in the payload phase
    a_pay_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY) |-> (cnt_reg < plen_reg))
        else $error("payload index reached frame length");

    // CRC byte count only moves in the CRC phase
    a_crc_cnt_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (crc_cnt_reg != 2'd0) |-> (phase_reg == PH_CRC))
        else $error("CRC byte count outside CRC phase");

    // Any frame-end report returns the parser to the hunt
    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && has_result && (res.result_kind != KIND_PAYLOAD)) |=>
        (phase_reg == PH_SOF1))
        else $error("frame end did not return to hunt");

endmodule

FILE: hw/rtl/crc_rx_out_stage.sv
// Output register of the receiver: holds one result beat until taken.
// Depends on crc_rx_pkg and crc_rx_result_if.
`timescale 1ns / 1ps

module crc_rx_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  crc_rx_pkg::result_t res,
    output logic                out_free,
    crc_rx_result_if.source     result
);
    import crc_rx_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign out_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

    assign result.valid          = valid_reg;
    assign result.result_kind    = data_reg.result_kind;
    assign result.payload_byte   = data_reg.payload_byte;
    assign result.payload_index  = data_reg.payload_index;
    assign result.frame_context  = data_reg.frame_context;
    assign result.frame_type     = data_reg.frame_type;
    assign result.frame_sequence = data_reg.frame_sequence;
    assign result.frame_length   = data_reg.frame_length;

    // Never overwrite a beat that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || result.ready))
        else $error("result overwritten while stalled");

endmodule
